FILE: design/ftpa_pkg.sv
`default_nettype none

package ftpa_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PID_W       = 8;
    localparam int ADDR_W      = 48;
    localparam int KEY_W       = PID_W + ADDR_W;
    localparam int SHIFT_W     = 6;
    localparam int PAGE_OUT_W  = 10;
    localparam int ENT_W       = 1 + KEY_W + IDX_W;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_CHECK  = 5'b10000
    } t_state;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] page;
    } t_entry;

    // xor fold of the key onto the slot index, kept below the table depth
    function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] key);
        logic [IDX_W-1:0] h;
        logic [IDX_W:0]   w;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % IDX_W] = h[i % IDX_W] ^ key[i];
        end
        if ({1'b0, h} >= (IDX_W + 1)'(TABLE_DEPTH)) begin
            w = {1'b0, h} - (IDX_W + 1)'(TABLE_DEPTH);
        end else begin
            w = {1'b0, h};
        end
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [PAGE_OUT_W-1:0] page_out(input logic [IDX_W-1:0] page);
        logic [IDX_W+PAGE_OUT_W-1:0] ext;
        ext = {{PAGE_OUT_W{1'b0}}, page};
        return ext[PAGE_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/ftpa_ram.sv
`default_nettype none

module ftpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/first_touch_page_allocator_unit.sv
`default_nettype none

// First-touch page allocator. Each item (program id, byte address) is reduced to a
// virtual page by the page_shift register and looked up in a hashed table of
// 1024 slots with linear probing; a new pair gets the next physical page in
// allocation order, and a miss on a full table returns page 0 with table_full.
// After reset a clearing pass writes every slot before the first item is taken.
// An item holds the input through HASH and then LOOKUP and CHECK for each probed slot,
// so the wait is shortest when the first slot decides and grows with table load; its
// result is registered when CHECK decides and the result register is free. A miss on a
// full table probes every slot. The registered read is why each probe needs LOOKUP and CHECK.
// One item is in work at a time; the result register lets the next item enter
// while a result still waits to be taken.
module first_touch_page_allocator_unit
    import ftpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [SHIFT_W-1:0]    i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PID_W-1:0]      i_program_id,
    input  wire logic [ADDR_W-1:0]     i_virtual_address,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PAGE_OUT_W-1:0]      o_physical_page,
    output logic                       o_was_hit,
    output logic                       o_table_full
);

    t_state                r_state, n_state;
    logic [SHIFT_W-1:0]    r_page_shift;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_probes, n_probes;
    logic [CNT_W-1:0]      r_next_free, n_next_free;
    logic                  r_out_valid, n_out_valid;
    logic [PAGE_OUT_W-1:0] r_out_page, n_out_page;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_full, n_out_full;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wentry;
    logic             ram_re;
    logic [ENT_W-1:0] ram_rdata;
    t_entry           rd_entry;
    logic             out_free;
    logic             produce;
    logic [ADDR_W-1:0] in_vpage;

    ftpa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry    = t_entry'(ram_rdata);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_vpage    = i_virtual_address >> r_page_shift;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign ram_re      = (r_state == S_LOOKUP);
    assign ram_waddr   = r_idx;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_idx       = r_idx;
        n_probes    = r_probes;
        n_next_free = r_next_free;
        n_out_page  = r_out_page;
        n_out_hit   = r_out_hit;
        n_out_full  = r_out_full;
        produce     = 1'b0;
        ram_we      = 1'b0;
        ram_wentry  = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = {i_program_id, in_vpage};
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_idx    = hash_key(r_key);
                n_probes = '0;
                n_state  = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (rd_entry.vld && rd_entry.key == r_key) begin
                    if (out_free) begin
                        produce    = 1'b1;
                        n_out_page = page_out(rd_entry.page);
                        n_out_hit  = 1'b1;
                        n_out_full = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else if (!rd_entry.vld) begin
                    if (out_free) begin
                        produce   = 1'b1;
                        n_out_hit = 1'b0;
                        n_state   = S_IDLE;
                        if (r_next_free == CNT_W'(TABLE_DEPTH)) begin
                            n_out_page = '0;
                            n_out_full = 1'b1;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wentry.vld  = 1'b1;
                            ram_wentry.key  = r_key;
                            ram_wentry.page = r_next_free[IDX_W-1:0];
                            n_next_free     = r_next_free + 1'b1;
                            n_out_page      = page_out(r_next_free[IDX_W-1:0]);
                            n_out_full      = 1'b0;
                        end
                    end
                end else if (r_probes == IDX_W'(TABLE_DEPTH - 1)) begin
                    if (out_free) begin
                        produce    = 1'b1;
                        n_out_page = '0;
                        n_out_hit  = 1'b0;
                        n_out_full = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_probes = r_probes + 1'b1;
                    n_idx    = (r_idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    n_state  = S_LOOKUP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (produce) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_next_free  <= '0;
            r_page_shift <= SHIFT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_page_shift <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_probes   <= n_probes;
        r_out_page <= n_out_page;
        r_out_hit  <= n_out_hit;
        r_out_full <= n_out_full;
    end

    assign o_out_valid     = r_out_valid;
    assign o_physical_page = r_out_page;
    assign o_was_hit       = r_out_hit;
    assign o_table_full    = r_out_full;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CNT_W'(TABLE_DEPTH))
        else $error("allocation count beyond table depth");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && !n_out_hit && !n_out_full) |=> r_next_free == $past(r_next_free) + 1'b1)
        else $error("new page without count step");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (o_physical_page == '0 && !o_was_hit))
        else $error("full result carries a page");

    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("item taken during clearing pass");

    a_write_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_CHECK) |-> (produce && !rd_entry.vld))
        else $error("table write outside a fresh allocation");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ftpa_pkg::*;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0] page;
        logic                  hit;
        logic                  full;
    } t_xlat;

    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [SHIFT_W-1:0]    i_cfg_data        = '0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_stall;
    logic [PID_W-1:0]      i_program_id      = '0;
    logic [ADDR_W-1:0]     i_virtual_address = '0;
    logic                  o_out_valid;
    logic                  i_out_stall       = 1'b0;
    logic [PAGE_OUT_W-1:0] o_physical_page;
    logic                  o_was_hit;
    logic                  o_table_full;

    // allocator mirror
    logic [KEY_W-1:0]   page_owner [TABLE_DEPTH];
    int                 pages_allocated = 0;
    logic [SHIFT_W-1:0] shift_cfg       = SHIFT_RESET;

    t_xlat             expected_xlat [$];
    logic [PID_W-1:0]  touched_pid   [$];
    logic [ADDR_W-1:0] touched_addr  [$];
    int                mismatches     = 0;
    int                send_gap_pct   = 0;
    int                recv_stall_pct = 0;

    first_touch_page_allocator_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_program_id      (i_program_id),
        .i_virtual_address (i_virtual_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_physical_page   (o_physical_page),
        .o_was_hit         (o_was_hit),
        .o_table_full      (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("first_touch_page_allocator_unit regression: fail");
        $finish;
    end

    function automatic int find_page(input logic [KEY_W-1:0] key);
        for (int i = 0; i < pages_allocated; i++) begin
            if (page_owner[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_xlat translate_access(input logic [PID_W-1:0] pid,
                                               input logic [ADDR_W-1:0] addr);
        logic [KEY_W-1:0] key;
        int               slot;
        t_xlat            r;
        key  = {pid, addr >> shift_cfg};
        slot = find_page(key);
        r    = '0;
        if (slot >= 0) begin
            r.page = PAGE_OUT_W'(slot);
            r.hit  = 1'b1;
        end else if (pages_allocated >= TABLE_DEPTH) begin
            r.full = 1'b1;
        end else begin
            page_owner[pages_allocated] = key;
            r.page = PAGE_OUT_W'(pages_allocated);
            pages_allocated++;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_xlat.size() == 0) begin
                $display("%0t: unexpected item page %0d hit %0b full %0b", $time,
                         o_physical_page, o_was_hit, o_table_full);
                mismatches++;
            end else begin
                want = expected_xlat.pop_front();
                if (o_physical_page !== want.page) begin
                    $display("%0t: physical_page expected %0d actual %0d", $time,
                             want.page, o_physical_page);
                    mismatches++;
                end
                if (o_was_hit !== want.hit) begin
                    $display("%0t: was_hit expected %0b actual %0b", $time,
                             want.hit, o_was_hit);
                    mismatches++;
                end
                if (o_table_full !== want.full) begin
                    $display("%0t: table_full expected %0b actual %0b", $time,
                             want.full, o_table_full);
                    mismatches++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic set_idling(input int gap_pct, input int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_access(input logic [PID_W-1:0] pid, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_program_id      <= pid;
        i_virtual_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        expected_xlat.push_back(translate_access(pid, addr));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_xlat.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_page_shift(input logic [SHIFT_W-1:0] shift);
        drain_results();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= shift;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shift_cfg = shift;
    endtask

    // reset page size, offsets within a page, pid and address extremes
    task automatic test_default_shift();
        set_idling(0, 0);
        send_access(8'd0, 48'h0);
        send_access(8'd0, 48'hFFF);
        send_access(8'd255, 48'h0);
        send_access(8'd0, 48'hFFFF_FFFF_FFFF);
        send_access(8'd255, 48'hFFFF_FFFF_FFFF);
        send_access(8'd255, 48'hFFFF_FFFF_F000);
        send_access(8'd0, 48'h1000);
        send_access(8'd0, 48'h0);
        drain_results();
    endtask

    // shift extremes, including shifts that drop every address bit
    task automatic test_shift_extremes();
        write_page_shift(6'd0);
        send_access(8'd0, 48'h0);
        send_access(8'd0, 48'h1);
        send_access(8'd0, 48'h1);
        write_page_shift(6'd63);
        send_access(8'd7, 48'hFFFF_FFFF_FFFF);
        send_access(8'd7, 48'h1234);
        write_page_shift(6'd48);
        send_access(8'd255, rand_address());
        write_page_shift(6'd40);
        send_access(8'd0, 48'hFFFF_FFFF_FFFF);
        send_access(8'd0, 48'hFF00_0000_0000);
        write_page_shift(6'd47);
        send_access(8'd0, 48'hFFFF_FFFF_FFFF);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [SHIFT_W-1:0] shifts [8] = '{6'd12, 6'd0, 6'd40, 6'd21, 6'd63, 6'd48,
                                           6'd7, 6'd30};
        logic [PID_W-1:0]   pid;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  offset_mask;
        int                 pick;
        int                 idx;
        for (int ph = 0; ph < 8; ph++) begin
            write_page_shift(shifts[ph]);
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(83, 0);
                2: set_idling(0, 83);
                default: set_idling(9, 9);
            endcase
            offset_mask = (shift_cfg >= 48) ? '1 : ((48'd1 << shift_cfg) - 48'd1);
            for (int n = 0; n < 40; n++) begin
                pick = $urandom_range(99, 0);
                if (pick < 60 && touched_pid.size() != 0) begin
                    // revisit a touched page at another offset
                    idx  = $urandom_range(touched_pid.size() - 1, 0);
                    pid  = touched_pid[idx];
                    addr = touched_addr[idx] ^ (rand_address() & offset_mask);
                end else begin
                    pid  = (pick < 80) ? PID_W'($urandom_range(3, 0))
                                       : PID_W'($urandom_range(255, 0));
                    addr = rand_address();
                    touched_pid.push_back(pid);
                    touched_addr.push_back(addr);
                end
                send_access(pid, addr);
            end
            drain_results();
        end
    endtask

    task automatic test_table_full();
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] addr;
        int                idx;
        write_page_shift(SHIFT_RESET);
        set_idling(0, 0);
        touched_pid.delete();
        touched_addr.delete();
        while (pages_allocated < TABLE_DEPTH) begin
            do begin
                pid  = PID_W'($urandom_range(255, 0));
                addr = rand_address();
            end while (find_page({pid, addr >> shift_cfg}) >= 0);
            touched_pid.push_back(pid);
            touched_addr.push_back(addr);
            send_access(pid, addr);
        end
        set_idling(9, 9);
        // last page handed out
        send_access(touched_pid[$], touched_addr[$]);
        for (int n = 0; n < 40; n++) begin
            if ($urandom_range(1, 0) == 1) begin
                idx = $urandom_range(touched_pid.size() - 1, 0);
                send_access(touched_pid[idx], touched_addr[idx] ^ ADDR_W'($urandom_range(4095, 0)));
            end else begin
                send_access(PID_W'($urandom_range(255, 0)), rand_address());
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_shift();
        test_shift_extremes();
        test_random_traffic();
        test_table_full();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_xlat.size() == 0) begin
            $display("first_touch_page_allocator_unit regression: pass");
        end else begin
            $display("first_touch_page_allocator_unit regression: fail");
        end
        $finish;
    end

endmodule
